// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; clock and reset are passed in by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/sfsf_pkg.sv =====
// Shared types and sizes for the scanline fill span finder.
// Used by every module of the block; depends on nothing.
package sfsf_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int PIX_W     = 32;
    localparam int POS_W     = 11;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int SPAN_W    = COL_W + 1;
    localparam int DATA_W    = ((2 * POS_W + 7) / 8) * 8;

    typedef struct packed {
        logic             frame_start;
        logic             row_end;
        logic [PIX_W-1:0] pixel;
    } item_t;

    typedef struct packed {
        logic             fill_valid;
        logic [POS_W-1:0] fill_end;
        logic [POS_W-1:0] fill_start;
    } result_t;

endpackage

// ===== src/sfsf_in_stage.sv =====
// Input register of the span finder: holds one pixel request.
// Depends on sfsf_pkg.
module sfsf_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sfsf_pkg::item_t in_item,
    input  logic           out_free,
    output logic           advance,
    output sfsf_pkg::item_t item
);
    import sfsf_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign advance  = vld_reg && out_free;
    assign in_ready = !vld_reg || advance;
    assign item     = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_ready)
        begin
            vld_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Capture a new request whenever the slot is free or drains this cycle.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== src/sfsf_span_core.sv =====
// Row state and span logic: classifies one pixel per cycle when advance
// is high and forms the span at row end. Depends on sfsf_pkg.
module sfsf_span_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic              advance,
    input  sfsf_pkg::item_t   item,
    output logic              res_valid,
    output sfsf_pkg::result_t result
);
    import sfsf_pkg::*;

    logic [PIX_W-1:0]  boundary_reg;
    logic [COL_W-1:0]  column_reg, column_next;
    logic              first_seen_reg, first_seen_next;
    logic [SPAN_W-1:0] first_pos_reg, first_pos_next;
    logic              in_run_reg, in_run_next;
    logic [SPAN_W-1:0] run_end_reg, run_end_next;
    logic              after_seen_reg, after_seen_next;
    logic [SPAN_W-1:0] after_pos_reg, after_pos_next;
    logic [SPAN_W-1:0] kept_start_reg, kept_start_next;
    logic              kept_start_ok_reg, kept_start_ok_next;
    logic [SPAN_W-1:0] kept_end_reg, kept_end_next;
    logic              kept_end_ok_reg, kept_end_ok_next;

    logic [COL_W-1:0]  col;
    logic [SPAN_W-1:0] col_pos;
    logic              hit;
    logic              fs;
    logic [SPAN_W-1:0] fp;
    logic              ifr;
    logic [SPAN_W-1:0] re;
    logic              as;
    logic [SPAN_W-1:0] ap;
    logic [SPAN_W-1:0] ks;
    logic              kso;
    logic [SPAN_W-1:0] ke;
    logic              keo;
    logic              have_start, have_end, span_ok;
    logic [SPAN_W-1:0] start_pos, end_pos;

    assign hit     = (item.pixel == boundary_reg);
    assign col     = item.frame_start ? '0 : column_reg;
    assign col_pos = {1'b0, col};
    assign ks      = item.frame_start ? '0 : kept_start_reg;
    assign kso     = item.frame_start ? 1'b0 : kept_start_ok_reg;
    assign ke      = item.frame_start ? '0 : kept_end_reg;
    assign keo     = item.frame_start ? 1'b0 : kept_end_ok_reg;

    // Pixel classification against the row state (cleared on frame start).
    always_comb
    begin
        fs  = item.frame_start ? 1'b0 : first_seen_reg;
        fp  = item.frame_start ? '0 : first_pos_reg;
        ifr = item.frame_start ? 1'b0 : in_run_reg;
        re  = item.frame_start ? '0 : run_end_reg;
        as  = item.frame_start ? 1'b0 : after_seen_reg;
        ap  = item.frame_start ? '0 : after_pos_reg;
        if (hit)
        begin
            if (!fs)
            begin
                fs  = 1'b1;
                fp  = col_pos;
                ifr = 1'b1;
                re  = col_pos + 1'b1;
            end
            else if (ifr)
            begin
                re = col_pos + 1'b1;
            end
            else
            begin
                as = 1'b1;
                ap = col_pos;
            end
        end
        else if (fs)
        begin
            ifr = 1'b0;
        end
    end

    // Span: after the first run to the last boundary, else kept start/end.
    always_comb
    begin
        have_start = 1'b0;
        have_end   = 1'b0;
        start_pos  = '0;
        end_pos    = '0;
        if (fs)
        begin
            if (!ifr)
            begin
                start_pos  = re;
                have_start = 1'b1;
            end
        end
        else if (kso && (ks <= col_pos))
        begin
            start_pos  = ks;
            have_start = 1'b1;
        end
        if (have_start)
        begin
            if (as)
            begin
                end_pos  = ap;
                have_end = 1'b1;
            end
            else if (keo)
            begin
                end_pos  = ke;
                have_end = 1'b1;
            end
        end
        span_ok = have_start && have_end && (end_pos > start_pos);
    end

    assign res_valid         = advance && item.row_end;
    assign result.fill_valid = span_ok;
    assign result.fill_start = span_ok ? POS_W'(start_pos) : '0;
    assign result.fill_end   = span_ok ? POS_W'(end_pos) : '0;

    always_comb
    begin
        column_next        = col;
        first_seen_next    = fs;
        first_pos_next     = fp;
        in_run_next        = ifr;
        run_end_next       = re;
        after_seen_next    = as;
        after_pos_next     = ap;
        kept_start_next    = ks;
        kept_start_ok_next = kso;
        kept_end_next      = ke;
        kept_end_ok_next   = keo;
        if (item.row_end)
        begin
            if (fs)
            begin
                kept_start_next    = fp;
                kept_start_ok_next = 1'b1;
            end
            if (have_start && as)
            begin
                kept_end_next    = ap;
                kept_end_ok_next = 1'b1;
            end
            // drop the row state for the next row
            column_next     = '0;
            first_seen_next = 1'b0;
            first_pos_next  = '0;
            in_run_next     = 1'b0;
            run_end_next    = '0;
            after_seen_next = 1'b0;
            after_pos_next  = '0;
        end
        else if (col < COL_W'(MAX_WIDTH - 1))
        begin
            column_next = col + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boundary_reg      <= '0;
            column_reg        <= '0;
            first_seen_reg    <= 1'b0;
            first_pos_reg     <= '0;
            in_run_reg        <= 1'b0;
            run_end_reg       <= '0;
            after_seen_reg    <= 1'b0;
            after_pos_reg     <= '0;
            kept_start_reg    <= '0;
            kept_start_ok_reg <= 1'b0;
            kept_end_reg      <= '0;
            kept_end_ok_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                boundary_reg <= cfg_wdata;
            end
            if (advance)
            begin
                column_reg        <= column_next;
                first_seen_reg    <= first_seen_next;
                first_pos_reg     <= first_pos_next;
                in_run_reg        <= in_run_next;
                run_end_reg       <= run_end_next;
                after_seen_reg    <= after_seen_next;
                after_pos_reg     <= after_pos_next;
                kept_start_reg    <= kept_start_next;
                kept_start_ok_reg <= kept_start_ok_next;
                kept_end_reg      <= kept_end_next;
                kept_end_ok_reg   <= kept_end_ok_next;
            end
        end
    end

endmodule

// ===== src/sfsf_out_stage.sv =====
// Result register of the span finder: holds one span until taken.
// Depends on sfsf_pkg.
module sfsf_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sfsf_pkg::result_t result,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              out_free,
    output sfsf_pkg::result_t out_result
);
    import sfsf_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign out_valid  = vld_reg;
    assign out_free   = !vld_reg || out_ready;
    assign out_result = res_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

endmodule

// ===== src/scanline_fill_span_finder.sv =====
// Scanline fill span finder.
// Input stream: one destination pixel per request; tlast marks row end,
// tuser marks frame start.
// Output stream: one span request per row, sent for the row-end pixel.
// Config: cfg_we/cfg_wdata write the boundary color; the user must write it
// only while idle, and the block itself does not enforce this.
// A row-end pixel is held in the input register, and the result register
// loads its span once that register is free.
// Throughput: one pixel per cycle while not stalled; the compare and the
// row-state update are combinational between the input and result registers.
// Stall: while a span waits on m_tready, pixels that do not end a row keep
// flowing; s_tready drops only when the result register is full, m_tready
// is low and the held pixel ends a row.
// Reset: clears the boundary color, column counter, row state and the
// spans kept across rows; both registers come up empty.
// A frame-start pixel clears the kept spans and begins column zero.
module scanline_fill_span_finder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [31:0]                cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,  // dest_pixel
    input  logic                       s_tlast,  // row_end
    input  logic                       s_tuser,  // frame_start
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sfsf_pkg::DATA_W-1:0] m_tdata, // fill_start, fill_end, zero pad
    output logic                       m_tuser   // fill_valid
);
    import sfsf_pkg::*;

    item_t   in_item;
    item_t   item;
    result_t result;
    result_t out_result;
    logic    advance;
    logic    out_free;
    logic    res_valid;

    assign in_item.pixel       = s_tdata;
    assign in_item.row_end     = s_tlast;
    assign in_item.frame_start = s_tuser;

    sfsf_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .out_free (out_free || !item.row_end),
        .advance  (advance),
        .item     (item)
    );

    sfsf_span_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .result    (result)
    );

    sfsf_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_valid),
        .result     (result),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_free   (out_free),
        .out_result (out_result)
    );

    assign m_tdata = {(DATA_W - 2 * POS_W)'(0), out_result.fill_end, out_result.fill_start};
    assign m_tuser = out_result.fill_valid;

endmodule

// ===== src/sfsf_checker.sv =====
// Port-level checks on the span finder's result stream.
// Depends on sfsf_pkg and assert_macros.svh; bound to the top level.
`include "assert_macros.svh"

module sfsf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [sfsf_pkg::DATA_W-1:0] m_tdata,
    input logic                        m_tuser
);
    import sfsf_pkg::*;

    `ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_hold_data, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `ASSERT_SAME(a_span_order, clk, rst_n, m_tvalid && m_tuser, m_tdata[2*POS_W-1:POS_W] > m_tdata[POS_W-1:0])
    `ASSERT_SAME(a_empty_zero, clk, rst_n, m_tvalid && !m_tuser, m_tdata == '0)

endmodule

bind scanline_fill_span_finder sfsf_checker u_sfsf_checker (.*);

// ===== tb/sv/tb_scanline_fill_span_finder.sv =====
// Self-checking testbench for scanline_fill_span_finder: drives pixel rows and
// predicts each row's span, checking every span request against that prediction.
// Depends on sfsf_pkg and the scanline_fill_span_finder RTL.
module tb_scanline_fill_span_finder;
    import sfsf_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 200;
    localparam int RANDOM_PHASES = 5;
    localparam int IDLE_PERCENT  = 30;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [31:0]       cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;   // dest_pixel
    logic              s_tlast;   // row_end
    logic              s_tuser;   // frame_start
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;   // fill_start, fill_end, zero pad
    logic              m_tuser;   // fill_valid

    result_t expected_spans[$];
    int      err_count   = 0;
    int      sent_pixels = 0;
    bit      sender_always_busy = 1'b0;
    bit      sink_always_ready  = 1'b0;
    bit      hold_request       = 1'b0;
    int      hold_left          = 0;

    // Span predictor state
    logic [31:0]      boundary;
    logic [POS_W-1:0] col_pos;
    logic             run_started;
    logic [POS_W-1:0] first_col;
    logic             in_run;
    logic [POS_W-1:0] after_run_col;
    logic             tail_seen;
    logic [POS_W-1:0] tail_col;
    logic [POS_W-1:0] keep_start;
    logic             keep_start_ok;
    logic [POS_W-1:0] keep_end;
    logic             keep_end_ok;

    scanline_fill_span_finder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic void clear_row_state();
        col_pos       = '0;
        run_started   = 1'b0;
        first_col     = '0;
        in_run        = 1'b0;
        after_run_col = '0;
        tail_seen     = 1'b0;
        tail_col      = '0;
    endfunction

    function automatic void clear_kept_span();
        keep_start    = '0;
        keep_start_ok = 1'b0;
        keep_end      = '0;
        keep_end_ok   = 1'b0;
    endfunction

    task automatic predict_pixel(input logic [31:0] pix, input logic last, input logic fs);
        logic [POS_W-1:0] c;
        logic [POS_W-1:0] width;
        logic [POS_W-1:0] span_start;
        logic [POS_W-1:0] span_stop;
        logic             have_start;
        logic             have_stop;
        logic             span_ok;
        result_t          span;
        if (fs)
        begin
            clear_row_state();
            clear_kept_span();
        end
        c = col_pos;
        if (pix == boundary)
        begin
            if (!run_started)
            begin
                run_started   = 1'b1;
                first_col     = c;
                in_run        = 1'b1;
                after_run_col = c + 1'b1;
            end
            else if (in_run)
                after_run_col = c + 1'b1;
            else
            begin
                tail_seen = 1'b1;
                tail_col  = c;
            end
        end
        else if (run_started)
            in_run = 1'b0;

        if (!last)
        begin
            // saturate at the last column of the widest row
            if (col_pos < MAX_WIDTH - 1)
                col_pos = col_pos + 1'b1;
        end
        else
        begin
            width      = c + 1'b1;
            span_start = '0;
            span_stop  = '0;
            have_start = 1'b0;
            have_stop  = 1'b0;
            if (run_started)
            begin
                keep_start    = first_col;
                keep_start_ok = 1'b1;
                if (!in_run)
                begin
                    span_start = after_run_col;
                    have_start = 1'b1;
                end
            end
            else if (keep_start_ok && keep_start < width)
            begin
                span_start = keep_start;
                have_start = 1'b1;
            end
            if (have_start)
            begin
                if (tail_seen)
                begin
                    span_stop   = tail_col;
                    keep_end    = tail_col;
                    keep_end_ok = 1'b1;
                    have_stop   = 1'b1;
                end
                else if (keep_end_ok)
                begin
                    span_stop = keep_end;
                    have_stop = 1'b1;
                end
            end
            span_ok         = have_start && have_stop && (span_stop > span_start);
            span.fill_start = span_ok ? span_start : '0;
            span.fill_end   = span_ok ? span_stop : '0;
            span.fill_valid = span_ok;
            expected_spans.push_back(span);
            clear_row_state();
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic send_pixel(input logic [31:0] pix, input logic last, input logic fs);
        while (!sender_always_busy && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= last;
        s_tuser  <= fs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_pixel(pix, last, fs);
        sent_pixels++;
        @(negedge clk);
    endtask

    // Drop the request and wait until every expected span has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_spans.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_boundary(input logic [31:0] color);
        cfg_we    <= 1'b1;
        cfg_wdata <= color;
        @(negedge clk);
        cfg_we   <= 1'b0;
        boundary  = color;
    endtask

    function automatic logic [31:0] background_pixel();
        logic [31:0] p;
        // mix fully random values with near misses of the boundary color
        p = $urandom_range(0, 1) ? $urandom : boundary ^ (32'h1 << $urandom_range(0, 31));
        if (p == boundary)
            p = ~boundary;
        return p;
    endfunction

    task automatic send_random_row(input logic fs_first);
        int          w;
        int          kind;
        int          a;
        int          b;
        int          c;
        int          d;
        logic [31:0] pix;
        logic        fs;
        w    = ($urandom_range(0, 39) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
        kind = $urandom_range(0, 9);
        a    = $urandom_range(0, w);
        b    = $urandom_range(a, w);
        c    = $urandom_range(b, w);
        d    = $urandom_range(c, w);
        for (int col = 0; col < w; col++)
        begin
            if (kind <= 6)
                pix = ((col >= a && col < b) || (col >= c && col < d)) ? boundary
                                                                       : background_pixel();
            else if (kind == 7)
                pix = background_pixel();
            else if (kind == 8)
                pix = ($urandom_range(0, 3) == 0) ? boundary : $urandom;
            else
                pix = boundary;
            // noisy rows may also restart the frame in the middle
            fs = (col == 0) ? fs_first : (kind == 8 && $urandom_range(0, 19) == 0);
            send_pixel(pix, col == w - 1, fs);
        end
    endtask

    // Boundary color left at its reset value of zero.
    task automatic test_reset_color();
        send_pixel(32'h0000_0000, 1'b0, 1'b1);
        send_pixel(32'h0000_0000, 1'b0, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_pixel(32'h0000_0005, 1'b0, 1'b0);
        send_pixel(32'h0000_0000, 1'b0, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b1, 1'b0);
        drain();
    endtask

    task automatic test_directed_cases();
        logic [31:0] bnd;
        logic [31:0] bg;
        bnd = 32'hFFFF_FFFF;
        bg  = 32'h0000_0000;
        write_boundary(bnd);
        // ordinary row: span from 2 to 4
        send_pixel(bg,  1'b0, 1'b1);
        send_pixel(bnd, 1'b0, 1'b0);
        send_pixel(bg,  1'b0, 1'b0);
        send_pixel(bg,  1'b0, 1'b0);
        send_pixel(bnd, 1'b0, 1'b0);
        send_pixel(bg,  1'b1, 1'b0);
        // no boundary: reuse kept start and end
        repeat (3) send_pixel(bg, 1'b0, 1'b0);
        send_pixel(bg, 1'b1, 1'b0);
        // kept start not inside this short row
        send_pixel(bg, 1'b1, 1'b0);
        // first run reaches the row end
        send_pixel(bg,  1'b0, 1'b0);
        send_pixel(bnd, 1'b0, 1'b0);
        send_pixel(bnd, 1'b1, 1'b0);
        // kept end lies before this row's start: empty span
        repeat (5) send_pixel(bg, 1'b0, 1'b0);
        send_pixel(bnd, 1'b0, 1'b0);
        send_pixel(bg,  1'b1, 1'b0);
        // single pixel row that is also a frame start
        send_pixel(bnd, 1'b1, 1'b1);
        drain();
    endtask

    // Row longer than the widest row: the column counter saturates.
    // Runs with no idling on either side.
    task automatic test_overlong_row();
        sender_always_busy = 1'b1;
        sink_always_ready  = 1'b1;
        write_boundary($urandom);
        send_pixel(boundary, 1'b0, 1'b1);
        for (int col = 1; col < MAX_WIDTH + 6; col++)
            send_pixel((col == MAX_WIDTH + 4) ? boundary : background_pixel(),
                       col == MAX_WIDTH + 5, 1'b0);
        drain();
        sender_always_busy = 1'b0;
        sink_always_ready  = 1'b0;
    endtask

    // Hold off the span side while short rows keep coming, then drain.
    task automatic test_backpressure();
        sender_always_busy = 1'b1;
        sink_always_ready  = 1'b1;
        hold_request       = 1'b1;
        for (int n = 0; n < 25; n++)
        begin
            send_pixel(boundary,  1'b0, n == 0);
            send_pixel(~boundary, 1'b0, 1'b0);
            send_pixel(boundary,  1'b0, 1'b0);
            send_pixel(~boundary, 1'b1, 1'b0);
        end
        drain();
        sender_always_busy = 1'b0;
        sink_always_ready  = 1'b0;
    endtask

    task automatic test_random_rows();
        int goal;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       write_boundary(32'h0000_0000);
                1:       write_boundary(32'hFFFF_FFFF);
                default: write_boundary($urandom);
            endcase
            // one phase runs with no idling on either side
            sender_always_busy = (phase == 2);
            sink_always_ready  = (phase == 2);
            goal = sent_pixels + RANDOM_ITEMS / RANDOM_PHASES;
            send_random_row(1'b1);
            while (sent_pixels < goal)
                send_random_row($urandom_range(0, 5) == 0);
            drain();
        end
        sender_always_busy = 1'b0;
        sink_always_ready  = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= sink_always_ready || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin : check_span
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_spans.size() == 0)
            begin
                $error("unexpected span request: fill_start %0d fill_end %0d fill_valid %0d",
                       m_tdata[POS_W-1:0], m_tdata[2*POS_W-1:POS_W], m_tuser);
                err_count++;
            end
            else
            begin
                want = expected_spans.pop_front();
                if (m_tdata[POS_W-1:0] !== want.fill_start)
                begin
                    $error("fill_start: expected %0d, actual %0d",
                           want.fill_start, m_tdata[POS_W-1:0]);
                    err_count++;
                end
                if (m_tdata[2*POS_W-1:POS_W] !== want.fill_end)
                begin
                    $error("fill_end: expected %0d, actual %0d",
                           want.fill_end, m_tdata[2*POS_W-1:POS_W]);
                    err_count++;
                end
                if (m_tuser !== want.fill_valid)
                begin
                    $error("fill_valid: expected %0d, actual %0d", want.fill_valid, m_tuser);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tuser   = 1'b0;
        boundary  = '0;
        clear_row_state();
        clear_kept_span();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_color();
        test_directed_cases();
        test_overlong_row();
        test_backpressure();
        test_random_rows();

        drain();
        if (err_count == 0 && expected_spans.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/sfsf_pkg.sv
src/sfsf_in_stage.sv
src/sfsf_span_core.sv
src/sfsf_out_stage.sv
src/scanline_fill_span_finder.sv
src/sfsf_checker.sv
tb/sv/tb_scanline_fill_span_finder.sv
